// File: hdl/sapc_pkg.sv
// Package for the set-associative position cache: sizes, codes and entry layout.
// No dependencies.
`default_nettype none
package sapc_pkg;
  localparam int unsigned IndexBits = 14;
  localparam int unsigned WayBits = 2;
  localparam int unsigned Ways = 4;
  localparam int unsigned AddrBits = IndexBits + WayBits;
  localparam int unsigned TagBits = 32;
  localparam logic [1:0] BoundExact = 2'd3;

  typedef enum logic [1:0] {
    ModeProbe = 2'd0,
    ModeStore = 2'd1,
    ModeClear = 2'd2
  } mode_e;

  localparam logic RegGeneration = 1'b0;
  localparam logic RegIndexBits = 1'b1;

  typedef struct packed {
    logic [7:0] age;
    logic [15:0] eval;
    logic [15:0] move;
    logic [15:0] depth;
    logic [1:0] bound;
    logic [15:0] score;
    logic [TagBits-1:0] tag;
  } entry_t;

  function automatic logic [3:0] eff_bits(input logic [3:0] b);
    return (b > 4'(IndexBits)) ? 4'(IndexBits) : b;
  endfunction
endpackage
`default_nettype wire

// File: hdl/set_assoc_position_cache.sv
// Top level of the set-associative position cache: entry memory and sequencer.
// Depends on sapc_pkg.
//
// Usage: requests enter on s_axis (tdata: mode[1:0], position_key[65:2],
// score_in[81:66], bound_in[83:82], depth_in[99:84], move_in[115:100],
// static_eval_in[131:116], zero fill to 136 bits). Results leave on m_axis
// (tdata: hit, score_out, bound_out, depth_out, move_out, static_eval_out,
// way_used from bit 0 up, zero fill to 72 bits). Registers are written on
// the cfg channel: index 0 search generation, index 1 index bits in use.
// A probe or store reads the ways of its cluster, up to four, through one memory
// read port, one way a cycle, and in a store one shared compare unit ranks each
// way against the current candidate. A request passes through the read and scan
// states, then the age state on a probe hit or the write state on a store, then
// the output state; an unused mode goes straight to output, and the next request
// is taken once the sequencer is idle. A clear writes one entry a cycle, all 65536
// entries. After reset the same clearing pass runs while s_axis is not ready;
// a resize that changes the index width also starts one. A result waits in the
// output register while m_axis_tready is low; one further request may be taken
// and worked on, and it holds in its last step until the output register frees.
`default_nettype none
module set_assoc_position_cache (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // mode, position_key, score_in, bound_in, depth_in, move_in, static_eval_in
  input  wire logic [135:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // hit, score_out, bound_out, depth_out, move_out, static_eval_out, way_used
  output logic [71:0]       m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic         cfg_index_i,
  input  wire logic [7:0]   cfg_data_i
);
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRead  = 7'b0000010,
    StScan  = 7'b0000100,
    StWrite = 7'b0001000,
    StOut   = 7'b0010000,
    StClear = 7'b0100000,
    StAge   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  sapc_pkg::entry_t mem [2**sapc_pkg::AddrBits];
  sapc_pkg::entry_t rd_q;
  logic [sapc_pkg::AddrBits-1:0] raddr, waddr;
  logic we;
  sapc_pkg::entry_t wdata;

  logic [7:0] gen_q;
  logic [3:0] ibits_q;
  logic [1:0] mode_q;
  logic [63:0] key_q;
  logic [15:0] score_q, depth_q, move_q, eval_q;
  logic [1:0] bound_q;
  logic [sapc_pkg::WayBits-1:0] way_q, cand_q;
  logic [sapc_pkg::WayBits-1:0] rcnt_q;
  logic found_q;
  logic cand_gen_q;
  logic signed [15:0] cand_depth_q;
  logic [15:0] oldmove_q;
  logic [sapc_pkg::AddrBits-1:0] clr_q;
  logic [71:0] res_q;
  logic [71:0] out_q;
  logic ovalid_q;
  logic out_free;
  logic [sapc_pkg::IndexBits-1:0] cl_idx;
  logic [sapc_pkg::IndexBits-1:0] mask;
  logic pend_clear_q;

  always_comb begin
    mask = '0;
    for (int i = 0; i < sapc_pkg::IndexBits; i++) begin
      mask[i] = (4'(i) < sapc_pkg::eff_bits(ibits_q));
    end
    cl_idx = key_q[sapc_pkg::IndexBits-1:0] & mask;
  end

  assign raddr = {cl_idx, rcnt_q};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  logic tag_ok, tag_empty, better;
  logic signed [2:0] s_val;
  always_comb begin
    tag_ok = rd_q.tag == key_q[63:32];
    tag_empty = rd_q.tag == '0;
    s_val = 3'(((rd_q.age == gen_q) || (rd_q.bound == sapc_pkg::BoundExact)) ? 1 : 0)
          - 3'(cand_gen_q ? 1 : 0)
          - 3'(($signed(rd_q.depth) < cand_depth_q) ? 1 : 0);
    better = s_val[2];
  end

  assign out_free = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && !pend_clear_q;
  assign cfg_ready_o = (state_q == StIdle) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = out_q;

  always_comb begin
    we = 1'b0;
    waddr = {cl_idx, way_q};
    wdata = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (pend_clear_q) state_d = StClear;
        else if (s_axis_tvalid && s_axis_tready) begin
          unique case (s_axis_tdata[1:0])
            sapc_pkg::ModeProbe, sapc_pkg::ModeStore: state_d = StRead;
            sapc_pkg::ModeClear: state_d = StClear;
            default: state_d = StOut;
          endcase
        end
      end
      StRead: state_d = StScan;
      StScan: begin
        if (mode_q == sapc_pkg::ModeProbe) begin
          if (tag_ok) state_d = StAge;
          else if (way_q == 2'(sapc_pkg::Ways - 1)) state_d = StOut;
        end else if (tag_ok || tag_empty || way_q == 2'(sapc_pkg::Ways - 1)) begin
          state_d = StWrite;
        end
      end
      StAge: begin
        we = 1'b1;
        waddr = {cl_idx, res_q[68:67]};
        wdata.tag = key_q[63:32];
        wdata.score = res_q[16:1];
        wdata.bound = res_q[18:17];
        wdata.depth = res_q[34:19];
        wdata.move = res_q[50:35];
        wdata.eval = res_q[66:51];
        wdata.age = gen_q;
        state_d = StOut;
      end
      StWrite: begin
        we = 1'b1;
        waddr = {cl_idx, cand_q};
        wdata.tag = key_q[63:32];
        wdata.score = score_q;
        wdata.bound = bound_q;
        wdata.depth = depth_q;
        wdata.move = (move_q == '0 && found_q) ? oldmove_q : move_q;
        wdata.eval = eval_q;
        wdata.age = gen_q;
        state_d = StOut;
      end
      StClear: begin
        we = 1'b1;
        waddr = clr_q;
        if (clr_q == '1) state_d = pend_clear_q ? StIdle : StOut;
      end
      StOut: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      gen_q <= '0;
      ibits_q <= 4'(sapc_pkg::IndexBits);
      ovalid_q <= 1'b0;
      pend_clear_q <= 1'b1;
      clr_q <= '0;
      rcnt_q <= '0;
      way_q <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && out_free) begin
        ovalid_q <= 1'b1;
        out_q <= res_q;
      end else if (m_axis_tvalid && m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == sapc_pkg::RegGeneration) gen_q <= cfg_data_i;
        else begin
          ibits_q <= cfg_data_i[3:0];
          if (sapc_pkg::eff_bits(cfg_data_i[3:0]) != sapc_pkg::eff_bits(ibits_q))
            pend_clear_q <= 1'b1;
        end
      end
      unique case (state_q)
        StIdle: begin
          rcnt_q <= '0;
          way_q <= '0;
          found_q <= 1'b0;
          clr_q <= '0;
          if (s_axis_tvalid && s_axis_tready) begin
            mode_q <= s_axis_tdata[1:0];
            key_q <= s_axis_tdata[65:2];
            score_q <= s_axis_tdata[81:66];
            bound_q <= s_axis_tdata[83:82];
            depth_q <= s_axis_tdata[99:84];
            move_q <= s_axis_tdata[115:100];
            eval_q <= s_axis_tdata[131:116];
            res_q <= '0;
            cand_q <= '0;
          end
        end
        StRead: rcnt_q <= rcnt_q + 1'b1;
        StScan: begin
          rcnt_q <= rcnt_q + 1'b1;
          if (mode_q == sapc_pkg::ModeProbe) begin
            if (tag_ok) begin
              res_q <= {3'd0, way_q, rd_q.eval, rd_q.move, rd_q.depth, rd_q.bound,
                        rd_q.score, 1'b1};
            end
          end else if (tag_ok || tag_empty) begin
            cand_q <= way_q;
            found_q <= 1'b1;
            oldmove_q <= rd_q.move;
          end else if (way_q == '0 || better) begin
            cand_q <= way_q;
            cand_gen_q <= rd_q.age == gen_q;
            cand_depth_q <= $signed(rd_q.depth);
          end
          way_q <= way_q + 1'b1;
        end
        StWrite: res_q <= {3'd0, cand_q, 67'd0};
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) pend_clear_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: test/tb_set_assoc_position_cache.sv
// Self-checking testbench for set_assoc_position_cache: directed and random
// probe, store, clear and unused-mode requests checked against a cycle-free predictor.
// Depends on sapc_pkg and the set_assoc_position_cache RTL.
`default_nettype none
module tb_set_assoc_position_cache;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int unsigned TableEntries = sapc_pkg::Ways << sapc_pkg::IndexBits;
  localparam int unsigned CycleLimit = 4000000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key;
    logic [15:0] score;
    logic [1:0]  bound;
    logic [15:0] depth;
    logic [15:0] move;
    logic [15:0] eval;
  } request_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] score;
    logic [1:0]  bound;
    logic [15:0] depth;
    logic [15:0] move;
    logic [15:0] eval;
    logic [1:0]  way;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = sapc_pkg::RegGeneration;
  logic [7:0] cfg_data_i = '0;

  set_assoc_position_cache i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sapc_pkg::entry_t cache_mem [TableEntries];
  logic [7:0] cur_gen = 8'd0;
  logic [3:0] cur_index_bits = 4'd14;

  request_t pending_reqs[$];
  lookup_t expected_lookups[$];
  int errors = 0;
  int cycles = 0;
  bit steady = 1'b0;
  bit req_taken = 1'b0;

  logic [31:0] tag_pool [8];
  logic [13:0] cluster_pool [4];

  function automatic logic [3:0] clamp_bits(logic [3:0] b);
    return (b > 4'(sapc_pkg::IndexBits)) ? 4'(sapc_pkg::IndexBits) : b;
  endfunction

  function automatic void wipe_cache();
    foreach (cache_mem[i]) cache_mem[i] = '0;
  endfunction

  function automatic lookup_t lookup_and_update(request_t r);
    lookup_t res;
    logic [31:0] tag;
    logic [63:0] mask;
    int base, e, c, cand, s;
    logic [15:0] mv;
    bit found;
    res = '0;
    tag = r.key[63:32];
    mask = (64'd1 << clamp_bits(cur_index_bits)) - 64'd1;
    base = int'(r.key & mask) * sapc_pkg::Ways;
    if (r.mode == sapc_pkg::ModeProbe) begin
      for (int i = 0; i < sapc_pkg::Ways; i++) begin
        e = base + i;
        if (cache_mem[e].tag == tag) begin
          cache_mem[e].age = cur_gen;
          res.hit = 1'b1;
          res.score = cache_mem[e].score;
          res.bound = cache_mem[e].bound;
          res.depth = cache_mem[e].depth;
          res.move = cache_mem[e].move;
          res.eval = cache_mem[e].eval;
          res.way = 2'(i);
          break;
        end
      end
    end else if (r.mode == sapc_pkg::ModeStore) begin
      mv = r.move;
      cand = 0;
      found = 1'b0;
      for (int i = 0; i < sapc_pkg::Ways && !found; i++) begin
        e = base + i;
        c = base + cand;
        if (cache_mem[e].tag == '0 || cache_mem[e].tag == tag) begin
          if (mv == '0) mv = cache_mem[e].move;
          cand = i;
          found = 1'b1;
        end else begin
          s = int'(cache_mem[e].age == cur_gen || cache_mem[e].bound == sapc_pkg::BoundExact)
            - int'(cache_mem[c].age == cur_gen)
            - int'($signed(cache_mem[e].depth) < $signed(cache_mem[c].depth));
          if (s < 0) cand = i;
        end
      end
      e = base + cand;
      cache_mem[e] = '{age: cur_gen, eval: r.eval, move: mv, depth: r.depth,
                       bound: r.bound, score: r.score, tag: tag};
      res.way = 2'(cand);
    end else if (r.mode == sapc_pkg::ModeClear) begin
      wipe_cache();
    end
    return res;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch on %s: got %h, expected %h", field, got, want);
  endtask

  always @(negedge clk_i) begin
    bit load;
    request_t r;
    load = !s_axis_tvalid || req_taken;
    if (load) begin
      if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
        r = pending_reqs.pop_front();
        s_axis_tdata <= {4'b0, r.eval, r.move, r.depth, r.bound, r.score, r.key, r.mode};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= steady || $urandom_range(99) >= 29;
  end

  always @(posedge clk_i) begin
    request_t r;
    lookup_t got, want;
    req_taken = s_axis_tvalid && s_axis_tready;
    if (req_taken) begin
      r.mode = s_axis_tdata[1:0];
      r.key = s_axis_tdata[65:2];
      r.score = s_axis_tdata[81:66];
      r.bound = s_axis_tdata[83:82];
      r.depth = s_axis_tdata[99:84];
      r.move = s_axis_tdata[115:100];
      r.eval = s_axis_tdata[131:116];
      expected_lookups.push_back(lookup_and_update(r));
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got.hit = m_axis_tdata[0];
      got.score = m_axis_tdata[16:1];
      got.bound = m_axis_tdata[18:17];
      got.depth = m_axis_tdata[34:19];
      got.move = m_axis_tdata[50:35];
      got.eval = m_axis_tdata[66:51];
      got.way = m_axis_tdata[68:67];
      if (expected_lookups.size() == 0) begin
        report("unexpected result", 64'(got), '0);
      end else begin
        want = expected_lookups.pop_front();
        if (got.hit != want.hit) report("hit", got.hit, want.hit);
        if (got.score != want.score) report("score_out", got.score, want.score);
        if (got.bound != want.bound) report("bound_out", got.bound, want.bound);
        if (got.depth != want.depth) report("depth_out", got.depth, want.depth);
        if (got.move != want.move) report("move_out", got.move, want.move);
        if (got.eval != want.eval) report("static_eval_out", got.eval, want.eval);
        if (got.way != want.way) report("way_used", got.way, want.way);
      end
    end
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [7:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == sapc_pkg::RegGeneration) begin
      cur_gen = data;
    end else begin
      if (clamp_bits(data[3:0]) != clamp_bits(cur_index_bits)) wipe_cache();
      cur_index_bits = data[3:0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_lookups.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic request_t make_req(logic [1:0] mode, logic [63:0] key);
    request_t r;
    r.mode = mode;
    r.key = key;
    r.score = 16'($urandom);
    r.bound = 2'($urandom);
    r.depth = ($urandom_range(1) == 0) ? 16'($urandom_range(12)) : 16'($urandom);
    r.move = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
    r.eval = 16'($urandom);
    return r;
  endfunction

  function automatic request_t random_req();
    int pick;
    logic [1:0] mode;
    logic [63:0] key;
    pick = $urandom_range(99);
    mode = (pick < 47) ? sapc_pkg::ModeProbe : (pick < 97) ? sapc_pkg::ModeStore : ModeUnused;
    if ($urandom_range(4) == 0)
      key = {32'($urandom), 32'($urandom)};
    else
      key = {tag_pool[$urandom_range(7)], 18'($urandom),
             cluster_pool[$urandom_range(3)]};
    return make_req(mode, key);
  endfunction

  task automatic random_phase(logic [7:0] gen, logic [7:0] bits, int n, bit with_clear);
    write_reg(sapc_pkg::RegGeneration, gen);
    write_reg(sapc_pkg::RegIndexBits, bits);
    for (int i = 0; i < 8; i++) tag_pool[i] = (i == 0) ? 32'd0 : 32'($urandom);
    for (int i = 0; i < 4; i++) cluster_pool[i] = 14'($urandom);
    for (int i = 0; i < n; i++) begin
      if (with_clear && i == n / 2)
        pending_reqs.push_back(make_req(sapc_pkg::ModeClear,
                                        {32'($urandom), 32'($urandom)}));
      pending_reqs.push_back(random_req());
    end
    wait_drained();
  endtask

  initial begin
    request_t r;
    logic [63:0] k;
    wipe_cache();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, tag zero, extremes, keep-move, replacement, clear
    k = {32'hA5A5_0001, 32'h0000_0005};
    pending_reqs.push_back(make_req(sapc_pkg::ModeProbe, 64'h0000_0000_0000_0005));
    pending_reqs.push_back(make_req(sapc_pkg::ModeProbe, k));
    r = make_req(sapc_pkg::ModeStore, k);
    r.score = 16'h8000; r.depth = 16'h7FFF; r.bound = 2'd0; r.move = 16'hFFFF;
    r.eval = 16'h7FFF;
    pending_reqs.push_back(r);
    r = make_req(sapc_pkg::ModeStore, k + 64'h1_0000_0000);
    r.score = 16'h7FFF; r.depth = 16'h8000; r.bound = sapc_pkg::BoundExact; r.move = 16'd0;
    r.eval = 16'h8000;
    pending_reqs.push_back(r);
    r = make_req(sapc_pkg::ModeStore, k + 64'h2_0000_0000);
    r.bound = 2'd1; r.depth = 16'd0;
    pending_reqs.push_back(r);
    r = make_req(sapc_pkg::ModeStore, k + 64'h3_0000_0000);
    r.bound = 2'd2; r.depth = 16'd3;
    pending_reqs.push_back(r);
    r = make_req(sapc_pkg::ModeStore, k);
    r.move = 16'd0;
    pending_reqs.push_back(r);
    for (int i = 0; i < 4; i++)
      pending_reqs.push_back(make_req(sapc_pkg::ModeProbe, k + (64'(i) << 32)));
    pending_reqs.push_back(make_req(sapc_pkg::ModeStore, 64'h0000_0000_0000_0005));
    pending_reqs.push_back(make_req(sapc_pkg::ModeProbe, 64'h0000_0000_0000_0005));
    pending_reqs.push_back(make_req(ModeUnused, '1));
    pending_reqs.push_back(make_req(sapc_pkg::ModeStore, '1));
    pending_reqs.push_back(make_req(sapc_pkg::ModeProbe, '1));
    wait_drained();
    write_reg(sapc_pkg::RegGeneration, 8'd9);
    pending_reqs.push_back(make_req(sapc_pkg::ModeStore, k + 64'h4_0000_0000));
    pending_reqs.push_back(make_req(sapc_pkg::ModeStore, k + 64'h5_0000_0000));
    pending_reqs.push_back(make_req(sapc_pkg::ModeProbe, k + 64'h4_0000_0000));
    pending_reqs.push_back(make_req(sapc_pkg::ModeClear, '1));
    pending_reqs.push_back(make_req(sapc_pkg::ModeProbe, k));
    pending_reqs.push_back(make_req(sapc_pkg::ModeProbe, '1));
    wait_drained();

    random_phase(8'd0, 8'd14, 140, 1'b0);
    random_phase(8'hFF, 8'hFF, 140, 1'b1);
    steady = 1'b1;
    random_phase(8'd7, 8'h01, 140, 1'b0);
    steady = 1'b0;
    random_phase(8'd8, 8'h00, 140, 1'b0);
    random_phase(8'd200, 8'hF3, 140, 1'b0);
    random_phase(8'd1, 8'd14, 130, 1'b0);

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
hdl/sapc_pkg.sv
hdl/set_assoc_position_cache.sv
test/tb_set_assoc_position_cache.sv
